[hdl/linear_probe_hash_table_macros.svh]
// assertion macros for the hash table rtl
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMPL(label, ante, cons)
`define LPHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/lpht_pkg.sv]
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIMIT_W = 9;
  localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = LIMIT_W'(192);

  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  mark;
    logic [31:0] key;
    logic [63:0] value;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } wr_req_t;

endpackage

[hdl/lpht_slot_ram.sv]
`timescale 1ns / 1ps
module lpht_slot_ram (
  input  logic                  clk,
  input  lpht_pkg::wr_req_t     wr,
  input  logic                  rd_en,
  input  logic [lpht_pkg::IDX_W-1:0] rd_addr,
  output lpht_pkg::slot_t       rd_data
);
  import lpht_pkg::*;

  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// Open-addressing key/value table with linear probing and tombstones. After reset the
// block runs a clearing pass over all CAPACITY (256) slots that marks every slot empty; no
// request is taken during it, while fill_limit writes are taken at any time. A request
// then runs in steps: the idle state accepts it and starts the first read, the probe
// state examines 1 up to CAPACITY slots in turn, and the finish state writes back and
// loads the result register once the output is free. Get or delete on an empty table
// and the reserved function code skip the probe state. Probing is paced by the single
// registered read port of the slot memory, which delivers one slot per cycle.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_fill_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_key_hash,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_value_out
);
  import lpht_pkg::*;
  `include "linear_probe_hash_table_macros.svh"

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   probe_n_r, probe_n_nxt;
  logic               have_tomb_r, have_tomb_nxt;
  logic [IDX_W-1:0]   tomb_idx_r, tomb_idx_nxt;
  logic [1:0]         func_r, func_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [63:0]        val_r, val_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]   wr_addr_r, wr_addr_nxt;
  slot_t              wr_data_r, wr_data_nxt;
  logic               inc_r, inc_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [63:0]        res_value_r, res_value_nxt;
  logic [CNT_W-1:0]   used_count_r, used_count_nxt;
  logic [LIMIT_W-1:0] fill_limit_r, fill_limit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [63:0]        out_value_r, out_value_nxt;

  wr_req_t          wr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;

  logic             out_free;
  logic             in_xact;
  logic             is_empty, is_hit, is_tomb, probe_done;
  logic             tomb_seen;
  logic [IDX_W-1:0] tomb_pick;
  logic             room_ok;

  lpht_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready     = rst_n;
  assign in_ready      = (state_r == S_IDLE);
  assign in_xact       = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  // slot examination for the entry now on the read port
  assign is_empty   = (rd_data.mark == MARK_EMPTY);
  assign is_hit     = (rd_data.mark == MARK_LIVE) && (rd_data.key == key_r);
  assign is_tomb    = !is_empty && (rd_data.mark != MARK_LIVE);
  assign probe_done = is_empty || is_hit || (&probe_n_r);
  assign tomb_seen  = have_tomb_r || is_tomb;
  assign tomb_pick  = have_tomb_r ? tomb_idx_r : idx_r;
  assign room_ok    = (CMP_W'(used_count_r) + CMP_W'(1)) <= CMP_W'(fill_limit_r);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    idx_nxt        = idx_r;
    probe_n_nxt    = probe_n_r;
    have_tomb_nxt  = have_tomb_r;
    tomb_idx_nxt   = tomb_idx_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    inc_nxt        = inc_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    used_count_nxt = used_count_r;
    fill_limit_nxt = fill_limit_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    wr             = '0;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    if (cfg_valid && cfg_ready) begin
      fill_limit_nxt = cfg_fill_limit;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr.en        = 1'b1;
        wr.addr      = clr_idx_r;
        wr.data      = '0;
        wr.data.mark = MARK_EMPTY;
        clr_idx_nxt  = clr_idx_r + IDX_W'(1);
        if (&clr_idx_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xact) begin
          func_nxt       = in_func;
          key_nxt        = in_key_id;
          val_nxt        = in_value_in;
          idx_nxt        = in_key_hash[IDX_W-1:0];
          probe_n_nxt    = '0;
          have_tomb_nxt  = 1'b0;
          wr_pend_nxt    = 1'b0;
          inc_nxt        = 1'b0;
          res_status_nxt = ST_MISS;
          res_value_nxt  = '0;
          if (in_func == FUNC_SET ||
              ((in_func == FUNC_GET || in_func == FUNC_DEL) && used_count_r != '0)) begin
            rd_en     = 1'b1;
            rd_addr   = in_key_hash[IDX_W-1:0];
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          state_nxt = S_FINISH;
          case (func_r)
            FUNC_SET: begin
              wr_data_nxt.mark  = MARK_LIVE;
              wr_data_nxt.key   = key_r;
              wr_data_nxt.value = val_r;
              if (is_hit) begin
                wr_pend_nxt    = 1'b1;
                wr_addr_nxt    = idx_r;
                res_status_nxt = ST_OK;
              end else if (tomb_seen) begin
                wr_pend_nxt    = 1'b1;
                wr_addr_nxt    = tomb_pick;
                res_status_nxt = ST_NEW;
              end else if (is_empty && room_ok) begin
                wr_pend_nxt    = 1'b1;
                wr_addr_nxt    = idx_r;
                inc_nxt        = 1'b1;
                res_status_nxt = ST_NEW;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            FUNC_GET: begin
              if (is_hit) begin
                res_status_nxt = ST_OK;
                res_value_nxt  = rd_data.value;
              end
            end
            default: begin
              // delete keeps key and value, only the mark turns into a tombstone
              if (is_hit) begin
                wr_pend_nxt      = 1'b1;
                wr_addr_nxt      = idx_r;
                wr_data_nxt      = rd_data;
                wr_data_nxt.mark = MARK_TOMB;
                res_status_nxt   = ST_OK;
              end
            end
          endcase
        end else begin
          if (is_tomb && !have_tomb_r) begin
            have_tomb_nxt = 1'b1;
            tomb_idx_nxt  = idx_r;
          end
          rd_en       = 1'b1;
          rd_addr     = idx_r + IDX_W'(1);
          idx_nxt     = idx_r + IDX_W'(1);
          probe_n_nxt = probe_n_r + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          wr.en          = wr_pend_r;
          wr.addr        = wr_addr_r;
          wr.data        = wr_data_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          if (inc_r) begin
            used_count_nxt = used_count_r + CNT_W'(1);
          end
          wr_pend_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      wr_pend_r    <= 1'b0;
      used_count_r <= '0;
      fill_limit_r <= FILL_LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      idx_r        <= idx_nxt;
      probe_n_r    <= probe_n_nxt;
      have_tomb_r  <= have_tomb_nxt;
      tomb_idx_r   <= tomb_idx_nxt;
      func_r       <= func_nxt;
      key_r        <= key_nxt;
      val_r        <= val_nxt;
      wr_pend_r    <= wr_pend_nxt;
      wr_addr_r    <= wr_addr_nxt;
      wr_data_r    <= wr_data_nxt;
      inc_r        <= inc_nxt;
      res_status_r <= res_status_nxt;
      res_value_r  <= res_value_nxt;
      used_count_r <= used_count_nxt;
      fill_limit_r <= fill_limit_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  `LPHT_ASSERT_IMPL(a_no_rw_overlap, wr.en, !rd_en)
  `LPHT_ASSERT_NEXT(a_accept_leaves_idle, in_xact, state_r == S_PROBE || state_r == S_FINISH)
  `LPHT_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_r), $past(state_r) == S_FINISH)
  `LPHT_ASSERT_IMPL(a_count_bound, 1'b1, used_count_r <= CNT_W'(CAPACITY))
  `LPHT_ASSERT_NEXT(a_probe_steps, state_r == S_PROBE && !probe_done,
                    state_r == S_PROBE && idx_r == $past(idx_r) + IDX_W'(1))

endmodule
